[rtl/shape_list_pixel_compositor_core_macros.svh]
// Assertion macros for the shape list pixel compositor.
`ifndef SHAPE_LIST_PIXEL_COMPOSITOR_CORE_MACROS_SVH
`define SHAPE_LIST_PIXEL_COMPOSITOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLPC_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("slpc assertion failed");

// Next-cycle implication, disabled during reset.
`define SLPC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("slpc assertion failed");

`endif

[rtl/slpc_pkg.sv]
// Shared constants and types for the shape list pixel compositor.
package slpc_pkg;

  localparam int MAX_SHAPES_DEF = 16;

  localparam logic [7:0] EMPTY_PIXEL = 8'h2E;

  localparam logic [8:0] CANVAS_ROWS_RST = 9'd64;
  localparam logic [8:0] CANVAS_COLS_RST = 9'd64;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_DEL = 2'd1;
  localparam logic [1:0] OP_QRY = 2'd2;

  localparam logic [1:0] KIND_RECT    = 2'd0;
  localparam logic [1:0] KIND_TRI_UP  = 2'd1;
  localparam logic [1:0] KIND_TRI_DN  = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] brush;
  } shape_t;

endpackage

[rtl/shape_list_pixel_compositor_core.sv]
// Shape list pixel compositor: shape table, add/delete/query sequencer.
//
// Input channel (s_*): one transfer carries one command; s_tuser holds the
// operation (add, delete, query pixel), s_tdata the shape fields.
// Output channel (m_*): exactly one result transfer per command.
// Configuration: cfg_we writes cfg_data into canvas rows (index 0) or
// canvas columns (index 1); write only while no command is in flight.
// Shapes live in a single-port-read, single-port-write table memory with a
// registered read port. An add checks and writes the shape in its own state;
// an invalid operation, an out-of-range delete, and a query outside the
// canvas or on an empty table go straight to the result state.
// Delete and query walk the table one entry per cycle through the memory
// read port; a delete writes each entry back one slot lower.
// One command is processed at a time; s_tready is high again as soon as a
// result is parked in the output register, even if it is not yet taken.
// If m_tready stays low, the next finished result waits until the output
// register frees up. Reset empties the table and restores a 64 x 64 canvas.
module shape_list_pixel_compositor_core #(
  parameter int MAX_SHAPES = slpc_pkg::MAX_SHAPES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] shape_kind, [9:2] center_x, [17:10] center_y, [25:18] shape_width,
  // [33:26] shape_height, [41:34] brush_char, [45:42] entry_index, [47:46] zero
  input  logic [47:0] s_tdata,
  // [1:0] operation
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [5:2] new_index, [13:6] pixel_value, [15:14] zero
  output logic [15:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  `include "shape_list_pixel_compositor_core_macros.svh"

  localparam int CNT_W = $clog2(MAX_SHAPES + 1);
  localparam int IDX_W = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_QRY  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic             rd_valid;
  logic [IDX_W-1:0] wb_addr;
  logic [8:0]       canvas_rows;
  logic [8:0]       canvas_cols;

  slpc_pkg::shape_t in_shape;
  logic [3:0]       in_idx;
  slpc_pkg::shape_t cur;
  slpc_pkg::shape_t rdata;

  logic [1:0] res_status;
  logic [3:0] res_new_index;
  logic [7:0] res_pixel;

  logic [1:0] out_status;
  logic [3:0] out_new_index;
  logic [7:0] out_pixel;
  logic       out_valid;
  logic       out_load;

  slpc_pkg::shape_t mem [MAX_SHAPES];

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  slpc_pkg::shape_t mem_wd;
  logic             rd_issue;
  logic             walk_done;
  logic             accept;
  logic             del_ok;
  logic             q_inside;
  logic [1:0]       chk;
  logic             add_ok;
  logic             hit;

  // input field unpacking
  assign in_shape.kind  = s_tdata[1:0];
  assign in_shape.x     = s_tdata[9:2];
  assign in_shape.y     = s_tdata[17:10];
  assign in_shape.w     = s_tdata[25:18];
  assign in_shape.h     = s_tdata[33:26];
  assign in_shape.brush = s_tdata[41:34];
  assign in_idx         = s_tdata[45:42];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign del_ok   = CMP_W'(in_idx) < CMP_W'(count);
  assign q_inside = ({1'b0, in_shape.x} < canvas_cols) && ({1'b0, in_shape.y} < canvas_rows);

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_pixel, out_new_index, out_status};
  assign out_load = (state == S_DONE) && (!out_valid || m_tready);

  // add checks on the latched shape
  logic [7:0] half_w;
  logic [7:0] half_h;
  logic       rect_in;
  logic       tri_in;
  assign half_w = cur.w >> 1;
  assign half_h = cur.h >> 1;
  assign rect_in = (cur.x >= half_w) && (cur.y >= half_h) &&
                   (({2'b00, cur.x} + {2'b00, half_w}) < {1'b0, canvas_cols}) &&
                   (({2'b00, cur.y} + {2'b00, half_h}) < {1'b0, canvas_rows});

  always_comb begin
    tri_in = ({1'b0, cur.x} < canvas_cols) && ({1'b0, cur.y} < canvas_rows) &&
             (({1'b0, cur.x} + 9'd1) >= {1'b0, cur.h}) &&
             (({1'b0, cur.x} + {1'b0, cur.h}) <= canvas_cols);
    if (cur.kind == slpc_pkg::KIND_TRI_UP) begin
      tri_in = tri_in && (({1'b0, cur.y} + {1'b0, cur.h}) <= canvas_rows);
    end else begin
      tri_in = tri_in && (({1'b0, cur.y} + 9'd1) >= {1'b0, cur.h});
    end
    case (cur.kind)
      slpc_pkg::KIND_RECT: begin
        if (!rect_in) begin
          chk = slpc_pkg::ST_OUTSIDE;
        end else if (!cur.w[0] || !cur.h[0]) begin
          chk = slpc_pkg::ST_INVALID;
        end else begin
          chk = slpc_pkg::ST_OK;
        end
      end
      slpc_pkg::KIND_TRI_UP, slpc_pkg::KIND_TRI_DN: begin
        chk = tri_in ? slpc_pkg::ST_OK : slpc_pkg::ST_OUTSIDE;
      end
      default: chk = slpc_pkg::ST_INVALID;
    endcase
  end

  assign add_ok = (chk == slpc_pkg::ST_OK) && (CNT_W'(MAX_SHAPES) != count);

  // coverage test of the entry just read against the query pixel
  logic signed [8:0] dxs;
  logic signed [8:0] dys;
  logic signed [8:0] dd;
  logic [7:0]        dx;
  logic [7:0]        dy;
  always_comb begin
    dxs = $signed({1'b0, cur.x}) - $signed({1'b0, rdata.x});
    dys = $signed({1'b0, cur.y}) - $signed({1'b0, rdata.y});
    dx  = dxs[8] ? 8'(-dxs) : dxs[7:0];
    dy  = dys[8] ? 8'(-dys) : dys[7:0];
    dd  = (rdata.kind == slpc_pkg::KIND_TRI_UP) ? dys : -dys;
    if (rdata.kind == slpc_pkg::KIND_RECT) begin
      hit = (dx <= (rdata.w >> 1)) && (dy <= (rdata.h >> 1));
    end else begin
      hit = !dd[8] && (dd[7:0] < rdata.h) && (dx <= dd[7:0]);
    end
  end

  assign rd_issue  = ((state == S_DEL) || (state == S_QRY)) && (ptr < count);
  assign walk_done = !rd_issue && !rd_valid;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wb_addr;
    mem_wd = rdata;
    if (state == S_ADD) begin
      mem_we = add_ok;
      mem_wa = IDX_W'(count);
      mem_wd = cur;
    end else if (state == S_DEL) begin
      mem_we = rd_valid;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_issue) begin
      rdata <= mem[IDX_W'(ptr)];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_rows <= slpc_pkg::CANVAS_ROWS_RST;
      canvas_cols <= slpc_pkg::CANVAS_COLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        slpc_pkg::REG_ROWS: canvas_rows <= cfg_data;
        slpc_pkg::REG_COLS: canvas_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= rd_issue;
      if (rd_issue) begin
        ptr     <= ptr + 1'b1;
        wb_addr <= IDX_W'(ptr) - 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur           <= in_shape;
            res_new_index <= '0;
            case (s_tuser)
              slpc_pkg::OP_ADD: begin
                res_status <= slpc_pkg::ST_OK;
                res_pixel  <= '0;
                state      <= S_ADD;
              end
              slpc_pkg::OP_DEL: begin
                res_status <= slpc_pkg::ST_OK;
                res_pixel  <= '0;
                if (del_ok) begin
                  ptr   <= CNT_W'(in_idx) + 1'b1;
                  state <= S_DEL;
                end else begin
                  state <= S_DONE;
                end
              end
              slpc_pkg::OP_QRY: begin
                res_status <= slpc_pkg::ST_OK;
                res_pixel  <= slpc_pkg::EMPTY_PIXEL;
                ptr        <= '0;
                if (q_inside && (count != '0)) begin
                  state <= S_QRY;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                res_status <= slpc_pkg::ST_INVALID;
                res_pixel  <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_ADD: begin
          if (add_ok) begin
            res_new_index <= 4'(count);
            count         <= count + 1'b1;
          end else if (chk == slpc_pkg::ST_OK) begin
            res_status <= slpc_pkg::ST_FULL;
          end else begin
            res_status <= chk;
          end
          state <= S_DONE;
        end
        S_DEL: begin
          if (walk_done) begin
            count <= count - 1'b1;
            state <= S_DONE;
          end
        end
        S_QRY: begin
          if (rd_valid && hit) begin
            res_pixel <= rdata.brush;
          end
          if (walk_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_status    <= res_status;
            out_new_index <= res_new_index;
            out_pixel     <= res_pixel;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SLPC_ASSERT_NOW(a_add_not_full, clk, rst, (state == S_ADD) && mem_we,
    count < CNT_W'(MAX_SHAPES))
  `SLPC_ASSERT_NEXT(a_del_shrinks, clk, rst, (state == S_DEL) && walk_done,
    count == $past(count) - 1'b1)
  `SLPC_ASSERT_NOW(a_walk_bound, clk, rst, (state == S_DEL) || (state == S_QRY),
    ptr <= count)
  `SLPC_ASSERT_NEXT(a_accept_busy, clk, rst, accept, !s_tready)

endmodule
